/* sv/dtgr_pkg.sv */
// Package for the dirty-tile gray renderer: field widths, register indexes,
// the drawing command record and default sizes. No dependencies.
`default_nettype none

package dtgr_pkg;

  // Fixed field widths
  localparam int COORD_W   = 6;
  localparam int DENS_W    = 16;
  localparam int GRAY_W    = 8;
  localparam int POS_W     = 11;
  localparam int GW_W      = 7;
  localparam int TS_W      = 4;
  localparam int ORG_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  // Linear cell index before wrapping: col + row * grid_width.
  localparam int SUM_W = COORD_W + GW_W;

  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

  // Default cache geometry
  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Result queue depth (power of two)
  localparam int OQ_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 3'd0,
    CFG_TILE_SIZE  = 3'd1,
    CFG_ORIGIN_X   = 3'd2,
    CFG_ORIGIN_Y   = 3'd3,
    CFG_DEBUG_MODE = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_FILL    = 1'b0,
    CMD_OUTLINE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [GRAY_W-1:0]  gray;
    logic               last;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/dirty_tile_gray_renderer_unit.sv */
// Dirty-tile gray renderer: top level with the per-cell gray cache.
// Depends on dtgr_pkg.
`default_nettype none

// A transaction passes through stages 1 to 4; the commands that it produces, if any, are
// written into the result queue from stage 4, the first offered on out_valid after that write.
// Throughput: one input per cycle while the result queue has room; the result port moves one
// command per cycle, so changed cells in debug mode, at two commands each, cannot keep that up.
// Reset: synchronous, active low. Registers take their defaults, then the whole cache is cleared
// one entry a cycle with in_ready low; writes are taken throughout.
module dirty_tile_gray_renderer_unit
  import dtgr_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [COORD_W-1:0]   in_col,
  input  wire logic [COORD_W-1:0]   in_row,
  input  wire logic [DENS_W-1:0]    in_density,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_cmd_kind,
  output logic [POS_W-1:0]          out_pos_x,
  output logic [POS_W-1:0]          out_pos_y,
  output logic [GRAY_W-1:0]         out_gray,
  output logic                      out_last,
  // configuration port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  // Cache geometry. The linear index wraps modulo DEPTH, which need not be a
  // power of two, so the remainder is formed by a reciprocal multiply, a
  // back-multiply and a single corrective subtract, each in its own stage.
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW      = $clog2(DEPTH + 1);
  localparam int PROD_W  = 2 * SUM_W + 1;
  localparam int MW      = SUM_W + DW;
  localparam int CW      = ((SUM_W > DW) ? SUM_W : DW) + 1;
  localparam int OQ_PW   = $clog2(OQ_DEPTH);
  localparam int OQ_CW   = OQ_PW + 1;
  localparam logic [SUM_W:0]   RECIP     = (SUM_W + 1)'((2 ** SUM_W) / DEPTH);
  localparam logic [OQ_CW-1:0] OQ_ROOM   = OQ_CW'(OQ_DEPTH - 2);
  localparam logic [AW-1:0]    CLR_LAST  = AW'(DEPTH - 1);

  // Configuration registers
  logic [GW_W-1:0]  grid_width_r;
  logic [TS_W-1:0]  tile_size_r;
  logic [ORG_W-1:0] origin_x_r;
  logic [ORG_W-1:0] origin_y_r;
  logic             debug_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r <= GW_W'(64);
      tile_size_r  <= TS_W'(4);
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      debug_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH: grid_width_r <= cfg_data[GW_W-1:0];
        CFG_TILE_SIZE:  tile_size_r  <= cfg_data[TS_W-1:0];
        CFG_ORIGIN_X:   origin_x_r   <= cfg_data[ORG_W-1:0];
        CFG_ORIGIN_Y:   origin_y_r   <= cfg_data[ORG_W-1:0];
        CFG_DEBUG_MODE: debug_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together. It advances only while the result
  // queue can take the two commands that the oldest stage may produce; this
  // depends on registered state alone, so in_ready has no path from out_ready.
  logic [OQ_CW-1:0] oq_count_r;
  logic             clearing_r;
  logic             adv;

  assign adv      = (oq_count_r <= OQ_ROOM);
  assign in_ready = adv && !clearing_r;

  // Stage 1: gray level, linear cell index and screen position.
  logic                  s1_valid_r;
  logic [SUM_W-1:0]      s1_sum_r;
  logic [GRAY_W-1:0]     s1_gray_r;
  logic [POS_W-1:0]      s1_px_r, s1_py_r;

  logic [SUM_W-1:0]      s0_sum;
  logic [GRAY_W-1:0]     s0_gray;
  logic [POS_W-1:0]      s0_px, s0_py;

  always_comb begin
    // density / 4, saturated at full white
    s0_gray = (|in_density[DENS_W-1:GRAY_W+2]) ? GRAY_MAX : in_density[GRAY_W+1:2];
    s0_sum  = SUM_W'(in_col) + SUM_W'(in_row) * SUM_W'(grid_width_r);
    s0_px   = POS_W'(in_col) * POS_W'(tile_size_r) + POS_W'(origin_x_r);
    s0_py   = POS_W'(in_row) * POS_W'(tile_size_r) + POS_W'(origin_y_r);
  end

  // Stage 2: quotient estimate, never more than one below the true quotient.
  logic                  s2_valid_r;
  logic [SUM_W-1:0]      s2_sum_r, s2_q_r;
  logic [GRAY_W-1:0]     s2_gray_r;
  logic [POS_W-1:0]      s2_px_r, s2_py_r;
  logic [PROD_W-1:0]     s1_prod;

  assign s1_prod = PROD_W'(s1_sum_r) * PROD_W'(RECIP);

  // Stage 3: partial remainder, below twice the cache depth.
  logic                  s3_valid_r;
  logic [SUM_W-1:0]      s3_rem_r;
  logic [GRAY_W-1:0]     s3_gray_r;
  logic [POS_W-1:0]      s3_px_r, s3_py_r;
  logic [MW-1:0]         s2_qd;
  logic [MW-1:0]         s2_diff;

  assign s2_qd   = MW'(s2_q_r) * MW'(DEPTH);
  assign s2_diff = MW'(s2_sum_r) - s2_qd;

  // Final correction gives the cache address; the read is issued here.
  logic [CW-1:0]         s3_rem_ext, s3_red;
  logic [AW-1:0]         s3_addr;

  always_comb begin
    s3_rem_ext = CW'(s3_rem_r);
    if (s3_rem_ext >= CW'(DEPTH)) begin
      s3_red = s3_rem_ext - CW'(DEPTH);
    end else begin
      s3_red = s3_rem_ext;
    end
    s3_addr = AW'(s3_red);
  end

  // Stage 4: cached gray arrives, compare, write back and queue commands.
  logic                  s4_valid_r;
  logic [AW-1:0]         s4_addr_r;
  logic [GRAY_W-1:0]     s4_gray_r;
  logic [POS_W-1:0]      s4_px_r, s4_py_r;
  logic [GRAY_W-1:0]     rd_data_r;

  // The item ahead of this one wrote on the same edge at which this one read
  // the cache, so its write is kept here and forwarded on an address match.
  logic                  fwd_valid_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [GRAY_W-1:0]     fwd_data_r;

  logic [GRAY_W-1:0]     s4_old;
  logic [GRAY_W:0]       s4_diff;
  logic                  s4_changed;
  logic                  s4_upd;
  cmd_t                  push0, push1;
  logic [1:0]            n_push;

  always_comb begin
    s4_old = (fwd_valid_r && (fwd_addr_r == s4_addr_r)) ? fwd_data_r : rd_data_r;
    if (s4_old > s4_gray_r) begin
      s4_diff = {1'b0, s4_old} - {1'b0, s4_gray_r};
    end else begin
      s4_diff = {1'b0, s4_gray_r} - {1'b0, s4_old};
    end
    s4_changed = (s4_diff > (GRAY_W + 1)'(1));
    s4_upd     = adv && s4_valid_r && s4_changed;

    push0.kind  = CMD_FILL;
    push0.pos_x = s4_px_r;
    push0.pos_y = s4_py_r;
    push0.gray  = s4_gray_r;
    push0.last  = !(debug_mode_r && s4_changed);

    push1.kind  = CMD_OUTLINE;
    push1.pos_x = s4_px_r;
    push1.pos_y = s4_py_r;
    push1.gray  = '0;
    push1.last  = 1'b1;

    n_push = 2'd0;
    if (adv && s4_valid_r) begin
      if (debug_mode_r) begin
        n_push = s4_changed ? 2'd2 : 2'd1;
      end else begin
        n_push = s4_changed ? 2'd1 : 2'd0;
      end
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_valid && in_ready;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      fwd_valid_r <= s4_valid_r && s4_changed;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r   <= s0_sum;
      s1_gray_r  <= s0_gray;
      s1_px_r    <= s0_px;
      s1_py_r    <= s0_py;

      s2_sum_r   <= s1_sum_r;
      s2_q_r     <= s1_prod[2*SUM_W-1:SUM_W];
      s2_gray_r  <= s1_gray_r;
      s2_px_r    <= s1_px_r;
      s2_py_r    <= s1_py_r;

      s3_rem_r   <= s2_diff[SUM_W-1:0];
      s3_gray_r  <= s2_gray_r;
      s3_px_r    <= s2_px_r;
      s3_py_r    <= s2_py_r;

      s4_addr_r  <= s3_addr;
      s4_gray_r  <= s3_gray_r;
      s4_px_r    <= s3_px_r;
      s4_py_r    <= s3_py_r;

      fwd_addr_r <= s4_addr_r;
      fwd_data_r <= s4_gray_r;
    end
  end

  // Clearing pass after reset: one zero written per cycle.
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == CLR_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Gray cache: one write port, one registered read port. No item is in the
  // pipeline while clearing, so the two writers never meet.
  logic [GRAY_W-1:0] cache_mem [DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [GRAY_W-1:0] mem_wdata;
  logic              mem_re;

  always_comb begin
    mem_we    = clearing_r || s4_upd;
    mem_waddr = clearing_r ? clr_addr_r : s4_addr_r;
    mem_wdata = clearing_r ? '0 : s4_gray_r;
    mem_re    = adv && s3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cache_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cache_mem[s3_addr];
    end
  end

  // Result queue: up to two commands in, one out per cycle.
  cmd_t             oq_mem [OQ_DEPTH];
  logic [OQ_PW-1:0] oq_wptr_r, oq_rptr_r;
  logic             oq_pop;
  cmd_t             oq_head;

  assign out_valid = (oq_count_r != '0);
  assign oq_pop    = out_valid && out_ready;
  assign oq_head   = oq_mem[oq_rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r  <= '0;
      oq_rptr_r  <= '0;
      oq_count_r <= '0;
    end else begin
      oq_wptr_r  <= oq_wptr_r + OQ_PW'(n_push);
      oq_rptr_r  <= oq_rptr_r + OQ_PW'(oq_pop);
      oq_count_r <= oq_count_r + OQ_CW'(n_push) - OQ_CW'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      oq_mem[oq_wptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      oq_mem[oq_wptr_r + OQ_PW'(1)] <= push1;
    end
  end

  assign out_cmd_kind = oq_head.kind;
  assign out_pos_x    = oq_head.pos_x;
  assign out_pos_y    = oq_head.pos_y;
  assign out_gray     = oq_head.gray;
  assign out_last     = oq_head.last;

endmodule

`default_nettype wire
